### rtl/core/plsh_pkg.sv
// ----------------------------------------------------------------------------
// plsh_pkg
// Shared widths, constants and pipeline beat types for the Phong shading core.
// ----------------------------------------------------------------------------
package plsh_pkg;

    // Packed component width and derived fraction widths
    localparam int CB        = 16;
    localparam int FRAC      = CB - 2;          // vector fraction bits
    localparam int NCOMP     = 3;
    localparam int POW_STEPS = 255;             // largest shininess exponent

    // 1.0 in vector fixed point
    localparam logic [FRAC:0] ONE_FX = (FRAC+1)'(1) << FRAC;

    // Beat handed from the geometry front end to the power chain
    typedef struct packed {
        logic [FRAC:0]                 p;       // running power of sc
        logic [FRAC:0]                 sc;      // clamped R.V
        logic [7:0]                    shin;    // exponent
        logic                          dlit;
        logic                          slit;
        logic [15:0]                   ks;
        logic [NCOMP-1:0][CB-1:0]      is_col;  // specular light color
        logic [NCOMP-1:0][CB+1:0]      diff;    // finished diffuse channels
    } t_pw_beat;

    // Payload carried alongside the front-end math
    typedef struct packed {
        logic [NCOMP-1:0][CB-1:0]      v;
        logic [15:0]                   kd;
        logic [15:0]                   ks;
        logic [7:0]                    shin;
        logic [NCOMP-1:0][CB-1:0]      id_col;
        logic [NCOMP-1:0][CB-1:0]      is_col;
    } t_carry;

endpackage

### rtl/core/plsh_geom.sv
// ----------------------------------------------------------------------------
// plsh_geom
// Six-stage front end: L.N, reflection, R.V, clamps and the diffuse term.
// ----------------------------------------------------------------------------
module plsh_geom (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [47:0]                  i_light_dir,
    input  logic [47:0]                  i_surface_normal,
    input  logic [47:0]                  i_view_dir,
    input  logic [15:0]                  i_diffuse_coef,
    input  logic [15:0]                  i_specular_coef,
    input  logic [7:0]                   i_shininess,
    input  logic [47:0]                  i_light_diffuse,
    input  logic [47:0]                  i_light_specular,
    output logic                         o_valid,
    output plsh_pkg::t_pw_beat           o_beat
);

    localparam int F  = plsh_pkg::FRAC;
    localparam int CB = plsh_pkg::CB;
    localparam int NC = plsh_pkg::NCOMP;

    logic [6:1] r_vld;

    // stage registers
    logic signed [2*CB-1:0]   r1_ln [NC];
    logic signed [CB-1:0]     r1_l  [NC];
    logic signed [CB-1:0]     r1_n  [NC];
    plsh_pkg::t_carry         r1_c;

    logic signed [CB+3:0]     r2_d;
    logic signed [CB-1:0]     r2_l  [NC];
    logic signed [CB-1:0]     r2_n  [NC];
    plsh_pkg::t_carry         r2_c;

    logic signed [2*CB+3:0]   r3_dn [NC];
    logic [30:0]              r3_traw;
    logic                     r3_dlit;
    logic signed [CB-1:0]     r3_l  [NC];
    plsh_pkg::t_carry         r3_c;

    logic signed [CB+7:0]     r4_r  [NC];
    logic [15:0]              r4_t;
    logic                     r4_dlit;
    plsh_pkg::t_carry         r4_c;

    logic signed [2*CB+7:0]   r5_rv [NC];
    logic [2*CB-1:0]          r5_dp [NC];
    logic                     r5_dlit;
    plsh_pkg::t_carry         r5_c;

    plsh_pkg::t_pw_beat       r6_beat;

    logic signed [2*CB+1:0]   w_acc_ln;
    logic                     w_dpos;
    logic [F:0]               w_dc;
    logic signed [2*CB+9:0]   w_acc_rv;
    logic signed [CB+11:0]    w_s;
    logic                     w_spos;
    plsh_pkg::t_carry         w_c0;

    // Unpack the slow payload
    always_comb begin
        w_c0.v      = i_view_dir;
        w_c0.kd     = i_diffuse_coef;
        w_c0.ks     = i_specular_coef;
        w_c0.shin   = i_shininess;
        w_c0.id_col = i_light_diffuse;
        w_c0.is_col = i_light_specular;
    end

    // Dot-product sums and clamps
    always_comb begin
        w_acc_ln = (2*CB+2)'(r1_ln[0]) + (2*CB+2)'(r1_ln[1]) + (2*CB+2)'(r1_ln[2]);
        w_dpos   = (r2_d > 0);
        w_dc     = !w_dpos ? '0 :
                   (r2_d > $signed((CB+4)'(plsh_pkg::ONE_FX))) ? plsh_pkg::ONE_FX :
                   r2_d[F:0];
        w_acc_rv = (2*CB+10)'(r5_rv[0]) + (2*CB+10)'(r5_rv[1]) + (2*CB+10)'(r5_rv[2]);
        w_s      = w_acc_rv[2*CB+9:F];
        w_spos   = (w_s > 0);
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:1], i_valid};
        end
    end

    // Advance the datapath
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NC; i++) begin
                r1_l[i]  <= $signed(i_light_dir[i*CB +: CB]);
                r1_n[i]  <= $signed(i_surface_normal[i*CB +: CB]);
                r1_ln[i] <= $signed(i_light_dir[i*CB +: CB])
                          * $signed(i_surface_normal[i*CB +: CB]);
            end
            r1_c <= w_c0;

            r2_d <= w_acc_ln[2*CB+1:F];
            r2_l <= r1_l;
            r2_n <= r1_n;
            r2_c <= r1_c;

            for (int i = 0; i < NC; i++) begin
                r3_dn[i] <= r2_d * r2_n[i];
            end
            r3_traw <= r2_c.kd * w_dc;
            r3_dlit <= w_dpos;
            r3_l    <= r2_l;
            r3_c    <= r2_c;

            // reflect L about N
            for (int i = 0; i < NC; i++) begin
                r4_r[i] <= (CB+8)'(r3_l[i])
                         - ((CB+8)'($signed(r3_dn[i][2*CB+3:F])) <<< 1);
            end
            r4_t    <= r3_traw[30:15];
            r4_dlit <= r3_dlit;
            r4_c    <= r3_c;

            for (int i = 0; i < NC; i++) begin
                r5_rv[i] <= r4_r[i] * $signed(r4_c.v[i]);
                r5_dp[i] <= r4_t * r4_c.id_col[i];
            end
            r5_dlit <= r4_dlit;
            r5_c    <= r4_c;

            // clamp R.V and seed the power chain
            r6_beat.p      <= plsh_pkg::ONE_FX;
            r6_beat.sc     <= !w_spos ? '0 :
                              (w_s > $signed((CB+12)'(plsh_pkg::ONE_FX))) ?
                              plsh_pkg::ONE_FX : w_s[F:0];
            r6_beat.shin   <= r5_c.shin;
            r6_beat.dlit   <= r5_dlit;
            r6_beat.slit   <= w_spos;
            r6_beat.ks     <= r5_c.ks;
            r6_beat.is_col <= r5_c.is_col;
            for (int i = 0; i < NC; i++) begin
                r6_beat.diff[i] <= r5_dp[i][2*CB-1:F];
            end
        end
    end

    assign o_valid = r_vld[6];
    assign o_beat  = r6_beat;

endmodule

### rtl/core/phong_light_shading_core.sv
// ----------------------------------------------------------------------------
// phong_light_shading_core
// Fixed-point Phong shading for one light: diffuse plus integer-power specular.
// ----------------------------------------------------------------------------
//  channel | valid    | ready    | payload
//  --------+----------+----------+-----------------------------------------
//  in      | i_valid  | o_ready  | i_light_dir .. i_light_specular
//  out     | o_valid  | i_ready  | o_red o_green o_blue, lit and sat flags
//
//  One beat per cycle while the output is taken. The pipe is six front-end
//  stages, one stage per possible exponent step (255, one 15x15 multiply
//  each), two specular scaling stages and the output register.
//  The whole pipe holds while the output register is full and not taken.
//  Reset clears every valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
module phong_light_shading_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [47:0]  i_light_dir,
    input  logic [47:0]  i_surface_normal,
    input  logic [47:0]  i_view_dir,
    input  logic [15:0]  i_diffuse_coef,
    input  logic [15:0]  i_specular_coef,
    input  logic [7:0]   i_shininess,
    input  logic [47:0]  i_light_diffuse,
    input  logic [47:0]  i_light_specular,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [15:0]  o_red,
    output logic [15:0]  o_green,
    output logic [15:0]  o_blue,
    output logic         o_diffuse_lit,
    output logic         o_specular_lit,
    output logic         o_saturated
);

    localparam int F  = plsh_pkg::FRAC;
    localparam int CB = plsh_pkg::CB;
    localparam int NC = plsh_pkg::NCOMP;
    localparam int NP = plsh_pkg::POW_STEPS;

    logic                 w_adv;
    logic                 w_geo_vld;
    plsh_pkg::t_pw_beat   w_geo;

    logic                 r_pw_vld [NP];
    plsh_pkg::t_pw_beat   r_pw     [NP];

    logic                 r_t1_vld;
    logic [30:0]          r_t1_uraw;
    plsh_pkg::t_pw_beat   r_t1;

    logic                 r_t2_vld;
    logic [2*CB-1:0]      r_t2_sp [NC];
    logic [NC-1:0][CB+1:0] r_t2_diff;
    logic                 r_t2_dlit;
    logic                 r_t2_slit;

    logic                 r_out_vld;
    logic [15:0]          r_out_ch [NC];
    logic                 r_out_dlit;
    logic                 r_out_slit;
    logic                 r_out_sat;

    logic [15:0]          w_u;
    logic [CB+2:0]        w_sum [NC];
    logic [NC-1:0]        w_clip;

    // Hold the whole pipe while the result waits
    assign w_adv   = !r_out_vld || i_ready;
    assign o_ready = w_adv;

    plsh_geom u_geom (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (w_adv),
        .i_valid          (i_valid),
        .i_light_dir      (i_light_dir),
        .i_surface_normal (i_surface_normal),
        .i_view_dir       (i_view_dir),
        .i_diffuse_coef   (i_diffuse_coef),
        .i_specular_coef  (i_specular_coef),
        .i_shininess      (i_shininess),
        .i_light_diffuse  (i_light_diffuse),
        .i_light_specular (i_light_specular),
        .o_valid          (w_geo_vld),
        .o_beat           (w_geo)
    );

    // Power chain: step k multiplies once more when k < shininess
    for (genvar k = 0; k < NP; k++) begin : g_pow
        logic                 w_prev_vld;
        plsh_pkg::t_pw_beat   w_prev;
        plsh_pkg::t_pw_beat   n_pw;
        logic [2*F+1:0]       w_prod;

        if (k == 0) begin : g_first
            assign w_prev_vld = w_geo_vld;
            assign w_prev     = w_geo;
        end else begin : g_next
            assign w_prev_vld = r_pw_vld[k-1];
            assign w_prev     = r_pw[k-1];
        end

        assign w_prod = w_prev.p * w_prev.sc;

        // Take one more power step while below the exponent
        always_comb begin
            n_pw = w_prev;
            if (w_prev.shin > 8'(k)) begin
                n_pw.p = w_prod[2*F:F];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pw_vld[k] <= 1'b0;
            end else if (w_adv) begin
                r_pw_vld[k] <= w_prev_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_pw[k] <= n_pw;
            end
        end
    end

    // Scale the specular power and combine channels
    always_comb begin
        w_u = r_t1.slit ? r_t1_uraw[30:15] : '0;
        for (int i = 0; i < NC; i++) begin
            w_sum[i]  = (CB+3)'(r_t2_diff[i] & {(CB+2){r_t2_dlit}})
                      + (CB+3)'(r_t2_sp[i][2*CB-1:F]);
            w_clip[i] = (w_sum[i] > (CB+3)'(16'hFFFF));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_vld  <= 1'b0;
            r_t2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_t1_vld  <= r_pw_vld[NP-1];
            r_t2_vld  <= r_t1_vld;
            r_out_vld <= r_t2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t1      <= r_pw[NP-1];
            r_t1_uraw <= r_pw[NP-1].ks * r_pw[NP-1].p;

            for (int i = 0; i < NC; i++) begin
                r_t2_sp[i] <= w_u * r_t1.is_col[i];
            end
            r_t2_diff <= r_t1.diff;
            r_t2_dlit <= r_t1.dlit;
            r_t2_slit <= r_t1.slit;

            // saturate each channel to u4.12
            for (int i = 0; i < NC; i++) begin
                r_out_ch[i] <= w_clip[i] ? 16'hFFFF : w_sum[i][15:0];
            end
            r_out_dlit <= r_t2_dlit;
            r_out_slit <= r_t2_slit;
            r_out_sat  <= |w_clip;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_red          = r_out_ch[0];
    assign o_green        = r_out_ch[1];
    assign o_blue         = r_out_ch[2];
    assign o_diffuse_lit  = r_out_dlit;
    assign o_specular_lit = r_out_slit;
    assign o_saturated    = r_out_sat;

endmodule
